@@ sv/ptsc_pkg.sv @@
// Shared types and constants for the polynomial term sorter.
package ptsc_pkg;

    localparam int PW = 16;
    localparam int CW = 32;
    localparam int TW = 31;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } back_state_t;

    typedef struct packed {
        logic signed [PW-1:0] power;
        logic signed [CW-1:0] coef;
        logic                 last;
        logic                 stored;
        logic                 ovf;
    } entry_t;

    typedef struct packed {
        logic          mode;
        logic [TW-1:0] threshold;
    } cfg_t;

    localparam logic CFG_MODE      = 1'b0;
    localparam logic CFG_THRESHOLD = 1'b1;

endpackage

@@ sv/ptsc_if.sv @@
// Stream interfaces for terms in and sorted terms out.
interface ptsc_term_if;
    import ptsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] term_power;
    logic signed [CW-1:0] term_coefficient;
    logic                 last_term;
    modport source (output valid, term_power, term_coefficient, last_term, input ready);
    modport sink (input valid, term_power, term_coefficient, last_term, output ready);
endinterface

interface ptsc_result_if;
    import ptsc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] out_power;
    logic signed [CW-1:0] out_coefficient;
    logic                 out_last;
    logic                 none_left;
    logic                 overflowed;
    modport source (output valid, out_power, out_coefficient, out_last, none_left,
                    overflowed, input ready);
    modport sink (input valid, out_power, out_coefficient, out_last, none_left,
                  overflowed, output ready);
endinterface

@@ sv/poly_term_sort_combine_top.sv @@
// Top level of the polynomial term sorter and combiner.
// Terms load one per cycle, while the queue has room, into a front counter and a
// four-entry queue; the back end pulls one queue entry per cycle while loading
// into a sorted insertion row of MAX_TERMS cells. After the last term it drains
// the row one cell per cycle while the output is not stalled, merging equal
// powers (mode 0) or dropping small terms (mode 1); the next polynomial queues
// while the row drains. No clearing pass is needed after reset.
module poly_term_sort_combine_top
    import ptsc_pkg::*;
#(
    parameter int MAX_TERMS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [TW-1:0] cfg_data,
    ptsc_term_if.sink     term,
    ptsc_result_if.source result
);
    cfg_t   cfg_reg, cfg_next;
    logic   push, push_ready, q_valid, q_pop;
    entry_t push_data, q_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:      cfg_next.mode      = cfg_data[0];
                CFG_THRESHOLD: cfg_next.threshold = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= 1'b0;
            cfg_reg.threshold <= TW'(1);
        end
        else
            cfg_reg <= cfg_next;
    end

    ptsc_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .clk(clk), .rst_n(rst_n), .term(term),
        .push(push), .push_data(push_data), .push_ready(push_ready)
    );

    ptsc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data), .push_ready(push_ready),
        .pop_valid(q_valid), .pop_data(q_data), .pop(q_pop)
    );

    ptsc_back #(.MAX_TERMS(MAX_TERMS)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .result(result)
    );
endmodule

@@ sv/ptsc_front.sv @@
// Front end: counts loads per polynomial, flags overflow, queues entries.
module ptsc_front
    import ptsc_pkg::*;
#(
    parameter int MAX_TERMS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    ptsc_term_if.sink term,
    output logic   push,
    output entry_t push_data,
    input  logic   push_ready
);
    localparam int NW = $clog2(MAX_TERMS + 1);

    logic [NW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          full;
    logic          take;

    assign term.ready = push_ready;
    assign take       = term.valid && push_ready;
    assign full       = (count_reg == NW'(MAX_TERMS));
    // dropped terms vanish unless they carry the end marker
    assign push       = take && (!full || term.last_term);

    always_comb
    begin
        push_data.power  = term.term_power;
        push_data.coef   = term.term_coefficient;
        push_data.last   = term.last_term;
        push_data.stored = !full;
        push_data.ovf    = ovf_reg || full;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (take)
        begin
            if (term.last_term)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (full)
                ovf_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule

@@ sv/ptsc_queue.sv @@
// Short entry queue between front and back.
module ptsc_queue
    import ptsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   push_ready,
    output logic   pop_valid,
    output entry_t pop_data,
    input  logic   pop
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign push_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ sv/ptsc_back.sv @@
// Back end: sorted insertion row, then merge/filter drain to the output register.
module ptsc_back
    import ptsc_pkg::*;
#(
    parameter int MAX_TERMS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   q_valid,
    input  entry_t q_data,
    output logic   q_pop,
    ptsc_result_if.source result
);
    localparam int SW = CW + $clog2(MAX_TERMS) + 1;
    localparam logic signed [SW-1:0] SMAX = SW'(64'sh7FFF_FFFF);
    localparam logic signed [SW-1:0] SMIN = -SW'(64'sh8000_0000);

    back_state_t state_reg, state_next;

    logic                 cv_reg [MAX_TERMS];
    logic signed [PW-1:0] cp_reg [MAX_TERMS];
    logic signed [CW-1:0] cc_reg [MAX_TERMS];
    logic                 cv_next [MAX_TERMS];
    logic signed [PW-1:0] cp_next [MAX_TERMS];
    logic signed [CW-1:0] cc_next [MAX_TERMS];
    logic                 ge [MAX_TERMS];
    logic [MAX_TERMS-1:0] vmask;

    logic                 ovf_reg, ovf_next;
    logic                 run_v_reg, run_v_next;
    logic signed [PW-1:0] run_p_reg, run_p_next;
    logic signed [SW-1:0] run_s_reg, run_s_next;
    logic                 pend_v_reg, pend_v_next;
    logic signed [PW-1:0] pend_p_reg, pend_p_next;
    logic signed [CW-1:0] pend_c_reg, pend_c_next;

    logic                 ov_reg, ov_next;
    logic signed [PW-1:0] op_reg, op_next;
    logic signed [CW-1:0] oc_reg, oc_next;
    logic                 ol_reg, ol_next;
    logic                 on_reg, on_next;
    logic                 oo_reg, oo_next;

    logic                 go, insert, shift, emit;
    logic [CW-1:0]        mag;
    logic                 keep;
    logic signed [CW-1:0] run_sat;

    assign go = !ov_reg || result.ready;

    always_comb
    begin
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            ge[i]    = cv_reg[i] && (cp_reg[i] >= q_data.power);
            vmask[i] = cv_reg[i];
        end
    end

    assign mag  = cc_reg[0][CW-1] ? CW'(-cc_reg[0]) : CW'(cc_reg[0]);
    // most negative value gives 2^31, above any threshold
    assign keep = !cfg.mode || (mag > {1'b0, cfg.threshold});

    always_comb
    begin
        if (run_s_reg > SMAX)
            run_sat = CW'(SMAX);
        else if (run_s_reg < SMIN)
            run_sat = CW'(SMIN);
        else
            run_sat = CW'(run_s_reg);
    end

    always_comb
    begin
        state_next  = state_reg;
        ovf_next    = ovf_reg;
        run_v_next  = run_v_reg;
        run_p_next  = run_p_reg;
        run_s_next  = run_s_reg;
        pend_v_next = pend_v_reg;
        pend_p_next = pend_p_reg;
        pend_c_next = pend_c_reg;
        op_next = op_reg;
        oc_next = oc_reg;
        ol_next = ol_reg;
        on_next = on_reg;
        q_pop  = 1'b0;
        insert = 1'b0;
        shift  = 1'b0;
        emit   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (q_valid)
                begin
                    q_pop  = 1'b1;
                    insert = q_data.stored;
                    if (q_data.last)
                    begin
                        ovf_next   = q_data.ovf;
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (go)
                begin
                    if (cv_reg[0])
                    begin
                        shift = 1'b1;
                        if (!cfg.mode && run_v_reg && cp_reg[0] == run_p_reg)
                            run_s_next = run_s_reg + SW'(cc_reg[0]);
                        else if (keep)
                        begin
                            // head starts a new run; finished run moves to pending
                            if (run_v_reg)
                            begin
                                emit        = pend_v_reg;
                                op_next     = pend_p_reg;
                                oc_next     = pend_c_reg;
                                ol_next     = 1'b0;
                                on_next     = 1'b0;
                                pend_v_next = 1'b1;
                                pend_p_next = run_p_reg;
                                pend_c_next = run_sat;
                            end
                            run_v_next = 1'b1;
                            run_p_next = cp_reg[0];
                            run_s_next = SW'(cc_reg[0]);
                        end
                    end
                    else if (run_v_reg)
                    begin
                        emit        = pend_v_reg;
                        op_next     = pend_p_reg;
                        oc_next     = pend_c_reg;
                        ol_next     = 1'b0;
                        on_next     = 1'b0;
                        pend_v_next = 1'b1;
                        pend_p_next = run_p_reg;
                        pend_c_next = run_sat;
                        run_v_next  = 1'b0;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        ol_next     = 1'b1;
                        on_next     = !pend_v_reg;
                        op_next     = pend_v_reg ? pend_p_reg : '0;
                        oc_next     = pend_v_reg ? pend_c_reg : '0;
                        pend_v_next = 1'b0;
                        state_next  = ST_LOAD;
                    end
                end
            end
            default:
                state_next = ST_LOAD;
        endcase
        ov_next = emit ? 1'b1 : (result.ready ? 1'b0 : ov_reg);
        // flag travels with the beat; the next polynomial may load while it waits
        oo_next = emit ? ovf_reg : oo_reg;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            cv_next[i] = cv_reg[i];
            cp_next[i] = cp_reg[i];
            cc_next[i] = cc_reg[i];
            if (shift)
            begin
                if (i == MAX_TERMS - 1)
                    cv_next[i] = 1'b0;
                else
                begin
                    cv_next[i] = cv_reg[i+1];
                    cp_next[i] = cp_reg[i+1];
                    cc_next[i] = cc_reg[i+1];
                end
            end
            else if (insert && !ge[i])
            begin
                // stable: new term goes behind all of equal or higher power
                cv_next[i] = 1'b1;
                if (i == 0 || ge[(i == 0) ? 0 : i-1])
                begin
                    cp_next[i] = q_data.power;
                    cc_next[i] = q_data.coef;
                end
                else
                begin
                    cv_next[i] = cv_reg[(i == 0) ? 0 : i-1];
                    cp_next[i] = cp_reg[(i == 0) ? 0 : i-1];
                    cc_next[i] = cc_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            ovf_reg    <= 1'b0;
            run_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
            for (int i = 0; i < MAX_TERMS; i++)
                cv_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovf_reg    <= ovf_next;
            run_v_reg  <= run_v_next;
            pend_v_reg <= pend_v_next;
            ov_reg     <= ov_next;
            for (int i = 0; i < MAX_TERMS; i++)
                cv_reg[i] <= cv_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        run_p_reg  <= run_p_next;
        run_s_reg  <= run_s_next;
        pend_p_reg <= pend_p_next;
        pend_c_reg <= pend_c_next;
        op_reg     <= op_next;
        oc_reg     <= oc_next;
        ol_reg     <= ol_next;
        on_reg     <= on_next;
        oo_reg     <= oo_next;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            cp_reg[i] <= cp_next[i];
            cc_reg[i] <= cc_next[i];
        end
    end

    assign result.valid           = ov_reg;
    assign result.out_power       = op_reg;
    assign result.out_coefficient = oc_reg;
    assign result.out_last        = ol_reg;
    assign result.none_left       = on_reg;
    assign result.overflowed      = oo_reg;

    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (vmask & (vmask + 1'b1)) == '0)
        else $error("row valid bits not a prefix");
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && on_reg |-> ol_reg)
        else $error("empty marker without last");
    a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LOAD |-> !run_v_reg && !pend_v_reg)
        else $error("leftover run while loading");
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg[1] |-> cp_reg[0] >= cp_reg[1])
        else $error("row head out of order");
endmodule
